[design/sha_pkg.sv]
// Package for the streaming SHA-256 hasher: constants, round table and helpers.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sha_pkg;

    localparam int WordWidth  = 32;
    localparam int CountWidth = 61;
    localparam int NumRounds  = 64;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitVec [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Byte operations that the controller asks of the datapath.
    typedef enum logic [1:0] {
        BYTE_NONE = 2'd0,
        BYTE_DATA = 2'd1,
        BYTE_PAD  = 2'd2,
        BYTE_ZERO = 2'd3
    } byte_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        byte_op_t   byte_op;     // write one byte at the fill position
        logic       count_byte;  // advance the message byte counter
        logic       load_len;    // write the bit length into words 14 and 15
        logic       round_init;  // copy the hash state into the working variables
        logic       round_step;  // run one round
        logic       fold;        // add the working variables into the hash state
        logic       restart;     // back to the initial vector, zero counter and fill
        logic       shift_out;   // rotate the hash state by one word for output
    } sha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;        // byte position within the current block
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[design/sha_datapath.sv]
// Datapath of the SHA-256 hasher: block buffer, schedule window, round unit and hash state.
// Depends on sha_pkg; driven by sha_ctrl.
`default_nettype none
module sha_datapath
    import sha_pkg::*;
#(
    parameter int CntW = CountWidth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sha_cmd_t    cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic [5:0]  round_idx,
    output sha_stat_t        stat,
    output logic [31:0]      head_word
);

    logic [31:0]     blk_reg [0:15];
    logic [31:0]     blk_next [0:15];
    logic [31:0]     hv_reg [0:7];
    logic [31:0]     hv_next [0:7];
    logic [31:0]     wv_reg [0:7];
    logic [31:0]     wv_next [0:7];
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [5:0]      fill_reg, fill_next;

    logic [7:0]  wr_byte;
    logic [63:0] bit_len;
    logic [31:0] w_lo, w_hi, s0, s1, w_new, w_cur;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    assign stat.fill = fill_reg;
    assign head_word = hv_reg[0];

    // Schedule word: the window of sixteen holds W[i..i+15] during round i.
    assign w_lo  = blk_reg[1];
    assign w_hi  = blk_reg[14];
    assign s0    = rotr(w_lo, 7) ^ rotr(w_lo, 18) ^ (w_lo >> 3);
    assign s1    = rotr(w_hi, 17) ^ rotr(w_hi, 19) ^ (w_hi >> 10);
    assign w_new = blk_reg[0] + s0 + blk_reg[9] + s1;
    assign w_cur = blk_reg[0];

    // Round functions.
    assign big1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
    assign ch   = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign t1   = wv_reg[7] + big1 + ch + RoundK[round_idx] + w_cur;
    assign big0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
    assign maj  = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                ^ (wv_reg[1] & wv_reg[2]);
    assign t2   = big0 + maj;

    assign bit_len = {cnt_reg, 3'b000};

    always_comb
    begin
        unique case (cmd.byte_op)
            BYTE_DATA: wr_byte = data_byte;
            BYTE_PAD:  wr_byte = PadByte;
            default:   wr_byte = 8'h00;
        endcase
    end

    // Next-state logic for the buffer, counters and state words.
    always_comb
    begin
        blk_next  = blk_reg;
        hv_next   = hv_reg;
        wv_next   = wv_reg;
        cnt_next  = cnt_reg;
        fill_next = fill_reg;

        if (cmd.byte_op != BYTE_NONE)
        begin
            unique case (fill_reg[1:0])
                2'd0: blk_next[fill_reg[5:2]] = {wr_byte, 24'h0};
                2'd1: blk_next[fill_reg[5:2]][23:16] = wr_byte;
                2'd2: blk_next[fill_reg[5:2]][15:8]  = wr_byte;
                default: blk_next[fill_reg[5:2]][7:0] = wr_byte;
            endcase
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_byte)
            cnt_next = cnt_reg + {{(CntW-1){1'b0}}, 1'b1};
        if (cmd.load_len)
        begin
            blk_next[14] = bit_len[63:32];
            blk_next[15] = bit_len[31:0];
        end
        if (cmd.round_init)
            wv_next = hv_reg;
        if (cmd.round_step)
        begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
            for (int i = 0; i < 15; i++)
                blk_next[i] = blk_reg[i + 1];
            blk_next[15] = w_new;
        end
        if (cmd.fold)
            for (int i = 0; i < 8; i++)
                hv_next[i] = hv_reg[i] + wv_reg[i];
        if (cmd.shift_out)
        begin
            for (int i = 0; i < 7; i++)
                hv_next[i] = hv_reg[i + 1];
            hv_next[7] = hv_reg[0];
        end
        if (cmd.restart)
        begin
            hv_next   = InitVec;
            cnt_next  = '0;
            fill_next = '0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= InitVec;
            wv_reg   <= '{default: '0};
            cnt_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            hv_reg   <= hv_next;
            wv_reg   <= wv_next;
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
        end
    end

    // Block buffer payload.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule
`default_nettype wire

[design/sha_ctrl.sv]
// Controller of the SHA-256 hasher: handshakes, padding sequence, rounds and output.
// Depends on sha_pkg; drives sha_datapath.
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       word_index,
    output logic             last_word,
    input  wire sha_stat_t   stat,
    output logic [5:0]       round_idx,
    output sha_cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PAD80 = 8'b0000_0010,
        ST_ZERO  = 8'b0000_0100,
        ST_LEN   = 8'b0000_1000,
        ST_INIT  = 8'b0001_0000,
        ST_ROUND = 8'b0010_0000,
        ST_FOLD  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] widx_reg, widx_next;
    logic       fin_reg, fin_next;    // padding in progress for this message
    logic       pad_reg, pad_next;    // message ended on a full block; 0x80 opens the next
    logic       last_reg, last_next;  // the block being compressed is the final one

    logic accept;

    assign round_idx  = rnd_reg;
    assign word_index = widx_reg;
    assign last_word  = (widx_reg == 3'd7);
    assign out_valid  = (state_reg == ST_OUT);
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.byte_op = BYTE_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present)
                    begin
                        cmd.byte_op    = BYTE_DATA;
                        cmd.count_byte = 1'b1;
                    end
                    if (byte_present && stat.fill == 6'd63)
                    begin
                        state_next = ST_INIT;
                        pad_next   = end_of_message;
                        last_next  = 1'b0;
                    end
                    else if (end_of_message)
                        state_next = ST_PAD80;
                end
            end
            ST_PAD80:
            begin
                cmd.byte_op = BYTE_PAD;
                fin_next    = 1'b0;
                if (stat.fill == 6'd63)
                begin
                    // No room for the length: compress, then a block of zeros.
                    state_next = ST_INIT;
                    last_next  = 1'b0;
                    fin_next   = 1'b1;
                end
                else if (stat.fill == 6'd55)
                    state_next = ST_LEN;
                else
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.byte_op = BYTE_ZERO;
                if (stat.fill == 6'd63)
                begin
                    state_next = ST_INIT;
                    last_next  = 1'b0;
                    fin_next   = 1'b1;
                end
                else if (stat.fill == 6'd55)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                // Fill now sits at 56; the length closes the block.
                cmd.load_len = 1'b1;
                state_next   = ST_INIT;
                last_next    = 1'b1;
                fin_next     = 1'b0;
            end
            ST_INIT:
            begin
                cmd.round_init = 1'b1;
                rnd_next       = '0;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                rnd_next       = rnd_reg + 6'd1;
                if (rnd_reg == 6'(NumRounds - 1))
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (last_reg)
                begin
                    state_next = ST_OUT;
                    widx_next  = '0;
                end
                else if (fin_reg)
                begin
                    // The 0x80 byte is already in: zero fill from a fresh block.
                    state_next = ST_ZERO;
                    fin_next   = 1'b0;
                end
                else if (pad_reg)
                begin
                    // Message ended with a full block: pad from the start of a fresh one.
                    state_next = ST_PAD80;
                    pad_next   = 1'b0;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    cmd.shift_out = 1'b1;
                    widx_next     = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        last_next   = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            widx_reg  <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

[design/sha256_stream_hasher_top.sv]
// Top level of the streaming SHA-256 hasher: joins the controller and the datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
//   channel | signals                                      | direction
//   input   | in_valid, in_stall, data_byte, byte_present, |  into block
//           | end_of_message                               |
//   output  | out_valid, out_stall, digest_word,           |  out of block
//           | word_index, last_word                        |
//
// A byte request is taken only while idle; the 64th byte of a block starts a compression
// (state copy, 64 rounds on the single round unit, fold) before the next byte is taken.
// An end request adds padding at one byte a cycle, one or two compressions,
// then eight digest words, one per cycle while out_stall is low.
// Reset is asynchronous and loads the initial vector; no clearing pass is needed.
// in_stall is high whenever the block is busy with a compression, padding or output.
`default_nettype none
module sha256_stream_hasher_top
    import sha_pkg::*;
#(
    parameter int CntW = CountWidth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [5:0] round_idx;

    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .stat           (stat),
        .round_idx      (round_idx),
        .cmd            (cmd)
    );

    sha_datapath #(
        .CntW (CntW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .round_idx (round_idx),
        .stat      (stat),
        .head_word (digest_word)
    );

endmodule
`default_nettype wire
